/* sv/sacl_pkg.sv */
`default_nettype none

package sacl_pkg;

	localparam int SETS       = 32;
	localparam int WAYS       = 4;
	localparam int LINE_BYTES = 16;

	localparam int ADDR_W   = 32;
	localparam int CNT_W    = 32;
	localparam int OFF_BITS = $clog2(LINE_BYTES);
	localparam int SET_BITS = $clog2(SETS);
	localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
	localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W    = AGE_W;

	typedef logic [IDX_W-1:0] set_idx_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [AGE_W-1:0] age_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [WAYS-1:0]  way_vec_t;

	// One memory row holds a whole set: every tag and every age.
	typedef struct packed {
		tag_t [WAYS-1:0] tag;
		age_t [WAYS-1:0] age;
	} row_t;

	typedef struct packed {
		logic     hit;
		way_t     way;
		row_t     row;
		way_vec_t valid;
	} lookup_t;

endpackage

`default_nettype wire

/* sv/set_assoc_cache_tag_lru.sv */
`default_nettype none

// Tag lookup for a 32-set, 4-way cache with 16-byte lines and true LRU
// replacement. Each address transfer returns hit or miss, the way hit or
// refilled, and running hit and miss totals that wrap at 32 bits. One access
// is taken per cycle while in_stall is low and goes through the memory read
// register, then the result registers. Each set is one row of a synchronous
// memory read when the address is taken and written back when its result is
// registered; a write-first bypass covers back-to-back same-set accesses.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module set_assoc_cache_tag_lru (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output       logic        in_stall,
	input  wire  logic [31:0] address,
	output       logic        out_valid,
	input  wire  logic        out_stall,
	output       logic        hit,
	output       logic [1:0]  way,
	output       logic [31:0] hit_count,
	output       logic [31:0] miss_count
);

	logic               vld_s1;
	sacl_pkg::set_idx_t set_s1;
	sacl_pkg::tag_t     tag_s1;

	logic               out_vld_q;
	logic               hit_q;
	sacl_pkg::way_t     way_q;
	logic [31:0]        hit_cnt_q;
	logic [31:0]        miss_cnt_q;

	sacl_pkg::way_vec_t valid_q [sacl_pkg::SETS];

	logic               accept;
	logic               adv;
	sacl_pkg::set_idx_t in_set;
	sacl_pkg::tag_t     in_tag;
	sacl_pkg::row_t     rd_row;
	sacl_pkg::lookup_t  res;

	assign in_set = sacl_pkg::set_idx_t'((address >> sacl_pkg::OFF_BITS) &
		32'(sacl_pkg::SETS - 1));
	assign in_tag = sacl_pkg::tag_t'(address >> (sacl_pkg::OFF_BITS + sacl_pkg::SET_BITS));

	assign adv      = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	sacl_row_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_set),
		.rd_data (rd_row),
		.wr_en   (adv),
		.wr_addr (set_s1),
		.wr_data (res.row)
	);

	sacl_lookup u_lookup (
		.row   (rd_row),
		.valid (valid_q[set_s1]),
		.tag   (tag_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < sacl_pkg::SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (adv) begin
			valid_q[set_s1] <= res.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b1;
				if (res.hit) begin
					hit_cnt_q <= hit_cnt_q + 32'd1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 32'd1;
				end
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= res.hit;
			way_q <= res.way;
		end
	end

	assign out_valid  = out_vld_q;
	assign hit        = hit_q;
	assign way        = 2'(way_q);
	assign hit_count  = hit_cnt_q;
	assign miss_count = miss_cnt_q;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with no item in flight");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("finished lookup did not reach the output");

	a_one_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (32'(hit_count + miss_count) ==
			32'($past(hit_count) + $past(miss_count) + 32'd1)))
		else $error("totals did not advance by exactly one");

	a_chosen_youngest: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.hit |-> (res.row.age[res.way] == '0))
		else $error("hit way not made youngest");

	a_chosen_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_q[$past(set_s1)][$past(res.way)])
		else $error("used way not valid after write back");
`endif

endmodule

`default_nettype wire

/* sv/sacl_row_ram.sv */
`default_nettype none

module sacl_row_ram (
	input  wire                logic clk,
	input  wire                logic rd_en,
	input  wire sacl_pkg::set_idx_t rd_addr,
	output      sacl_pkg::row_t     rd_data,
	input  wire                logic wr_en,
	input  wire sacl_pkg::set_idx_t wr_addr,
	input  wire sacl_pkg::row_t     wr_data
);

	sacl_pkg::row_t mem [sacl_pkg::SETS];
	sacl_pkg::row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Write-first: a read that meets a write to the same set takes the new row.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* sv/sacl_lookup.sv */
`default_nettype none

module sacl_lookup (
	input  wire sacl_pkg::row_t     row,
	input  wire sacl_pkg::way_vec_t valid,
	input  wire sacl_pkg::tag_t     tag,
	output      sacl_pkg::lookup_t  res
);

	sacl_pkg::row_t     cur;
	sacl_pkg::row_t     nxt;
	sacl_pkg::way_vec_t nxt_valid;
	logic               hit;
	logic               found_old;
	logic               move;
	sacl_pkg::way_t     chosen;
	sacl_pkg::age_t     prev;

	always_comb begin
		cur = row;
		// A set with no valid way was never written: ages read as way numbers.
		if (valid == '0) begin
			for (int w = 0; w < sacl_pkg::WAYS; w++) begin
				cur.age[w] = sacl_pkg::age_t'(w);
			end
		end

		hit    = 1'b0;
		chosen = '0;
		for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
			if (valid[w] && (cur.tag[w] == tag)) begin
				hit    = 1'b1;
				chosen = sacl_pkg::way_t'(w);
			end
		end

		found_old = 1'b0;
		if (!hit) begin
			for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
				if (cur.age[w] == sacl_pkg::age_t'(sacl_pkg::WAYS - 1)) begin
					found_old = 1'b1;
					chosen    = sacl_pkg::way_t'(w);
				end
			end
		end

		// Promote the chosen way, age every way younger than it.
		move = hit || found_old;
		prev = cur.age[chosen];
		nxt  = cur;
		for (int w = 0; w < sacl_pkg::WAYS; w++) begin
			if (move) begin
				if (sacl_pkg::way_t'(w) == chosen) begin
					nxt.age[w] = '0;
				end else if (cur.age[w] < prev) begin
					nxt.age[w] = cur.age[w] + sacl_pkg::age_t'(1);
				end
			end
		end

		nxt_valid = valid;
		if (!hit) begin
			nxt.tag[chosen]   = tag;
			nxt_valid[chosen] = 1'b1;
		end

		res.hit   = hit;
		res.way   = chosen;
		res.row   = nxt;
		res.valid = nxt_valid;
	end

endmodule

`default_nettype wire

/* bench/set_assoc_cache_tag_lru_test.sv */
module set_assoc_cache_tag_lru_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sacl_pkg::*;

	localparam int RANDOM_ITEMS = 1230;
	localparam int CALM_ITEMS   = 150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		logic [31:0] addr;
		bit          known;
		logic        hit;
		way_t        way;
		logic [31:0] hits;
		logic [31:0] misses;
	} access_row_t;

	typedef struct {
		logic        hit;
		way_t        way;
		logic [31:0] hits;
		logic [31:0] misses;
	} access_outcome_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [31:0] address   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic [1:0]  way;
	logic [31:0] hit_count;
	logic [31:0] miss_count;

	set_assoc_cache_tag_lru dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.way(way),
		.hit_count(hit_count),
		.miss_count(miss_count)
	);

	// Shadow copy of the tag array, valid bits, LRU ages and totals.
	tag_t        shadow_tag   [SETS][WAYS];
	logic        shadow_valid [SETS][WAYS];
	age_t        shadow_age   [SETS][WAYS];
	logic [31:0] hits_seen;
	logic [31:0] misses_seen;

	access_row_t     typed_q[$];
	access_outcome_t pending_results[$];
	access_outcome_t predicted_now;
	access_outcome_t due_now;
	access_row_t     note_now;
	int              mismatch_count = 0;
	int              cycle_count    = 0;
	bit              calm           = 1'b0;

	localparam int DIRECTED_ROWS = 20;
	access_row_t directed_rows [DIRECTED_ROWS] = '{
		// first access after reset refills the oldest way, which is way 3
		'{32'h0000_0000, 1'b1, 1'b0, 2'd3, 32'd0, 32'd1},
		'{32'h0000_000F, 1'b1, 1'b1, 2'd3, 32'd1, 32'd1},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 2'd3, 32'd1, 32'd2},
		'{32'hFFFF_FFF0, 1'b1, 1'b1, 2'd3, 32'd2, 32'd2},
		// fill set 0, hit the oldest, then evict
		'{32'h0000_0200, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0400, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0600, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0004, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0800, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0200, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		// tag zero in an untouched set must miss on the invalid ways
		'{32'h0000_0010, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0018, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'hFFFF_FE00, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h5555_5555, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_01F0, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'hFFFF_FFF8, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h8000_0000, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0400, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0},
		'{32'h0000_0600, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				shadow_tag[s][w]   = '0;
				shadow_valid[s][w] = 1'b0;
				shadow_age[s][w]   = age_t'(w);
			end
		end
		hits_seen   = '0;
		misses_seen = '0;
	end

	// Make way w youngest and age every way that was younger than it.
	function automatic void promote(input int s, input way_t w);
		age_t prev;
		prev = shadow_age[s][w];
		shadow_age[s][w] = '0;
		for (int k = 0; k < WAYS; k++)
			if (way_t'(k) != w && shadow_age[s][k] < prev)
				shadow_age[s][k] = shadow_age[s][k] + age_t'(1);
	endfunction

	function automatic access_outcome_t lookup_and_update(input logic [31:0] a);
		logic [31:0]     line_no;
		int              s;
		tag_t            t;
		bit              matched;
		bit              victim_found;
		access_outcome_t r;
		line_no = a / LINE_BYTES;
		s = line_no % SETS;
		t = tag_t'(line_no / SETS);
		matched = 1'b0;
		victim_found = 1'b0;
		r.way = '0;
		for (int k = 0; k < WAYS; k++) begin
			if (!matched && shadow_valid[s][k] && shadow_tag[s][k] == t) begin
				matched = 1'b1;
				r.way = way_t'(k);
			end
		end
		if (matched) begin
			hits_seen = hits_seen + 1;
			promote(s, r.way);
		end else begin
			misses_seen = misses_seen + 1;
			// no oldest way leaves way 0 chosen and the ages untouched
			for (int k = 0; k < WAYS; k++) begin
				if (!victim_found && shadow_age[s][k] == age_t'(WAYS - 1)) begin
					victim_found = 1'b1;
					r.way = way_t'(k);
					promote(s, r.way);
				end
			end
			shadow_tag[s][r.way]   = t;
			shadow_valid[s][r.way] = 1'b1;
		end
		r.hit = matched;
		r.hits = hits_seen;
		r.misses = misses_seen;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		if (mismatch_count < SHOWN_ERRORS)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v)
			note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, exp_v, act_v));
	endtask

	// Predict on every address transfer, check every result transfer.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predicted_now = lookup_and_update(address);
			note_now = typed_q.pop_front();
			if (note_now.known)
				pending_results.push_back('{note_now.hit, note_now.way, note_now.hits,
					note_now.misses});
			else
				pending_results.push_back(predicted_now);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: hit=%0d way=%0d", hit, way));
			end else begin
				due_now = pending_results.pop_front();
				compare_field("hit", 32'(due_now.hit), 32'(hit));
				compare_field("way", 32'(due_now.way), 32'(way));
				compare_field("hit_count", due_now.hits, hit_count);
				compare_field("miss_count", due_now.misses, miss_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_access(input access_row_t row);
		typed_q.push_back(row);
		in_valid <= 1'b1;
		address  <= row.addr;
		do @(posedge clk); while (in_stall);
	endtask

	// Gaps come in bursts; every third stretch of a hundred transfers has none.
	task automatic sender_gap(input int n);
		if (!calm && ((n / 100) % 3 != 2) && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || typed_q.size() != 0);
	endtask

	initial begin : result_stall
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 40)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		tag_t             tag_pool [8];
		access_row_t      row;
		tag_t             t;
		set_idx_t         s;
		logic [OFF_BITS-1:0] off;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_access(directed_rows[i]);
			sender_gap(i);
		end
		wait_drained();

		// Small tag pool so sets see hits, LRU reordering and evictions.
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int k = 2; k < 8; k++)
			tag_pool[k] = tag_t'($urandom);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			row = '{32'h0, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0};
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 1) == 0)
					s = set_idx_t'($urandom_range(0, 3));
				else
					s = set_idx_t'($urandom);
				t = tag_pool[$urandom_range(0, ($urandom_range(0, 1) == 0) ? 4 : 7)];
				off = OFF_BITS'($urandom);
				row.addr = {t, s, off};
			end else begin
				row.addr = $urandom;
			end
			send_access(row);
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			else
				sender_gap(n);
		end
		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
